// ----- src/planar_tile_row_renderer_defines.svh -----
// ----------------------------------------------------------------------------
// Planar tile row renderer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef PLANAR_TILE_ROW_RENDERER_DEFINES_SVH
`define PLANAR_TILE_ROW_RENDERER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PTR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/ptr_pkg.sv -----
// ----------------------------------------------------------------------------
// Planar tile row renderer package
// Screen and color table constants, shared types and color helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ptr_pkg;

  localparam int SCREEN_W   = 256;
  localparam int SCREEN_H   = 240;
  localparam int CT_ENTRIES = 64;
  localparam int CT_AW      = $clog2(CT_ENTRIES);

  localparam int ENT_W   = 6;   // palette byte bits used as table index
  localparam int RGB_W   = 24;
  localparam int COL_W   = 16;
  localparam int ADDR_W  = 16;
  localparam int COORD_W = 12;  // signed screen coordinate with headroom
  localparam int PIX_N   = 8;
  localparam int PIX_IW  = $clog2(PIX_N);
  localparam int GRAY_STEP = 85;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } opcode_e;

  // Draw item held between acceptance and row decode.
  typedef struct packed {
    logic [7:0]                plane_low;
    logic [7:0]                plane_high;
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_line;
    logic signed [COORD_W-1:0] tile_y;
    logic                      pal_zero;
    logic [2:0]                ent_ok;    // index k-1: entry for color index k exists
  } cap_t;

  // Decoded row ready for pixel-by-pixel emission.
  typedef struct packed {
    logic [PIX_N-1:0]            mask;
    logic [PIX_N-1:0][COL_W-1:0] color;
    logic [ADDR_W-1:0]           base;
    logic signed [COORD_W-1:0]   x_right;  // x of bit 0
  } row_t;

  function automatic logic [COL_W-1:0] rgb565(input logic [RGB_W-1:0] rgb);
    rgb565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

  function automatic logic [COL_W-1:0] gray565(input logic [1:0] idx);
    logic [9:0] prod;
    logic [7:0] g;
    prod = 10'(idx) * 10'(GRAY_STEP);
    g    = prod[7:0];
    gray565 = rgb565({g, g, g});
  endfunction

endpackage

`default_nettype wire

// ----- src/ptr_color_ram.sv -----
// ----------------------------------------------------------------------------
// Color table RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_color_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ptr_pkg::CT_AW-1:0] waddr_i,
  input  logic [ptr_pkg::RGB_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ptr_pkg::CT_AW-1:0] raddr_i,
  output logic [ptr_pkg::RGB_W-1:0] rdata_o
);
  import ptr_pkg::*;

  logic [RGB_W-1:0] mem [CT_ENTRIES];
  logic [RGB_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/ptr_row_decode.sv -----
// ----------------------------------------------------------------------------
// Tile row decode
// Clips the row, forms the pixel indices and resolves the color per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_row_decode (
  input  ptr_pkg::cap_t                           cap_i,
  input  logic [2:0][ptr_pkg::RGB_W-1:0]          rgb_i,
  output ptr_pkg::row_t                           row_o
);
  import ptr_pkg::*;

  localparam logic signed [COORD_W-1:0] SW = COORD_W'(SCREEN_W);
  localparam logic signed [COORD_W-1:0] SH = COORD_W'(SCREEN_H);

  logic                      row_ok;
  logic [3:0][COL_W-1:0]     idx_color;
  logic [31:0]               base_prod;
  logic signed [COORD_W-1:0] x_right;

  always_comb begin
    row_ok = (cap_i.x_origin < SW) && (cap_i.tile_y < SH) &&
             (cap_i.x_origin + COORD_W'(PIX_N) > 0) &&
             (cap_i.tile_y + COORD_W'(PIX_N) > 0) &&
             (cap_i.y_line >= 0) && (cap_i.y_line < SH);
    idx_color[0] = '0;
    for (int k = 1; k < 4; k++) begin
      if (cap_i.pal_zero) begin
        idx_color[k] = gray565(2'(k));
      end else if (cap_i.ent_ok[k-1]) begin
        idx_color[k] = rgb565(rgb_i[k-1]);
      end else begin
        idx_color[k] = '0;
      end
    end
  end

  assign x_right   = cap_i.x_origin + COORD_W'(PIX_N - 1);
  assign base_prod = 32'(cap_i.y_line[COORD_W-2:0]) * 32'(SCREEN_W);

  always_comb begin
    logic signed [COORD_W-1:0] xc;
    logic [1:0]                idx;
    row_o.base    = base_prod[ADDR_W-1:0];
    row_o.x_right = x_right;
    for (int c = 0; c < PIX_N; c++) begin
      xc  = x_right - COORD_W'(c);
      idx = {cap_i.plane_high[c], cap_i.plane_low[c]};
      row_o.color[c] = idx_color[idx];
      // Transparent, clipped and black pixels produce no write.
      row_o.mask[c]  = row_ok && (xc >= 0) && (xc < SW) &&
                       (idx != 2'd0) && (idx_color[idx] != '0);
    end
  end

endmodule

`default_nettype wire

// ----- src/ptr_pixel_emitter.sv -----
// ----------------------------------------------------------------------------
// Pixel emitter
// Holds one decoded row and sends its pixels through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "planar_tile_row_renderer_defines.svh"

module ptr_pixel_emitter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cap_valid_i,
  input  ptr_pkg::row_t              row_i,
  output logic                       row_load_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ptr_pkg::ADDR_W-1:0] pixel_address_o,
  output logic [ptr_pkg::COL_W-1:0]  pixel_color_o,
  output logic                       last_pixel_o
);
  import ptr_pkg::*;

  logic [PIX_N-1:0] mask_q, mask_d;
  row_t             row_q;
  logic             out_valid_q;
  logic [ADDR_W-1:0] addr_q;
  logic [COL_W-1:0]  color_q;
  logic              last_q;

  logic [PIX_IW-1:0]         sel;
  logic [PIX_N-1:0]          rest;
  logic signed [COORD_W-1:0] x_sel;
  logic                      out_take;
  logic                      emit;
  logic                      row_load;

  always_comb begin
    sel = '0;
    for (int c = PIX_N - 1; c >= 0; c--) begin
      if (mask_q[c]) begin
        sel = PIX_IW'(c);
      end
    end
  end

  assign rest     = mask_q & ~(PIX_N'(1) << sel);
  assign x_sel    = row_q.x_right - COORD_W'(sel);
  assign out_take = out_valid_q && !out_stall_i;
  assign emit     = (mask_q != '0) && (!out_valid_q || out_take);
  // The row register frees up when it holds no pending pixel or its last one is emitted this cycle.
  assign row_load = (mask_q == '0) || (emit && (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (row_load) begin
      mask_d = cap_valid_i ? row_i.mask : '0;
    end else if (emit) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_load) begin
      row_q <= row_i;
    end
    if (emit) begin
      addr_q  <= row_q.base + ADDR_W'(x_sel);
      color_q <= row_q.color[sel];
      last_q  <= (rest == '0);
    end
  end

  assign row_load_o      = row_load;
  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign pixel_color_o   = color_q;
  assign last_pixel_o    = last_q;

  `PTR_ASSERT_NOW(a_color_nonzero, out_valid_q, color_q != '0)
  `PTR_ASSERT_NOW(a_addr_on_screen, out_valid_q,
                  32'(addr_q) < 32'(SCREEN_W * SCREEN_H))
  `PTR_ASSERT_NEXT(a_row_continues, out_take && !last_q, out_valid_q)

endmodule

`default_nettype wire

// ----- src/planar_tile_row_renderer.sv -----
// A draw beat is captured with its color table reads, decoded, and its first
// pixel enters the output register. One pixel beat per cycle while out_stall_i
// is low; a row holds the emitter until its last drawn pixel is sent. Load
// beats are taken one per cycle while in_stall_o is low. The color table has
// three single-read-port copies, read at acceptance. Reset clears only the
// handshake and pipeline valid state; the table is undefined until loaded.
// ----------------------------------------------------------------------------
// Planar tile row renderer
// Loads a color table and decodes 2-bit planar tile rows into RGB565 framebuffer pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_tile_row_renderer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [5:0]                 entry_index_i,
  input  logic [23:0]                entry_rgb_i,
  input  logic [7:0]                 plane_low_i,
  input  logic [7:0]                 plane_high_i,
  input  logic signed [9:0]          x_origin_i,
  input  logic signed [9:0]          y_line_i,
  input  logic signed [9:0]          tile_y_origin_i,
  input  logic [31:0]                palette_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ptr_pkg::ADDR_W-1:0] pixel_address_o,
  output logic [ptr_pkg::COL_W-1:0]  pixel_color_o,
  output logic                       last_pixel_o
);
  import ptr_pkg::*;

  logic                        cap_valid_q;
  cap_t                        cap_q, cap_d;
  logic                        accept;
  logic                        is_draw;
  logic                        row_load;
  logic                        load_we;
  logic [2:0][ENT_W-1:0]       ent;
  logic [2:0][RGB_W-1:0]       rgb;
  row_t                        row;

  assign is_draw    = (opcode_i == OP_DRAW);
  assign in_stall_o = cap_valid_q && !row_load;
  assign accept     = in_valid_i && !in_stall_o;
  assign load_we    = accept && !is_draw && (32'(entry_index_i) < 32'(CT_ENTRIES));

  // Palette bytes for color indices 1, 2 and 3.
  assign ent[0] = palette_word_i[16 +: ENT_W];
  assign ent[1] = palette_word_i[8 +: ENT_W];
  assign ent[2] = palette_word_i[0 +: ENT_W];

  always_comb begin
    cap_d.plane_low  = plane_low_i;
    cap_d.plane_high = plane_high_i;
    cap_d.x_origin   = COORD_W'(x_origin_i);
    cap_d.y_line     = COORD_W'(y_line_i);
    cap_d.tile_y     = COORD_W'(tile_y_origin_i);
    cap_d.pal_zero   = (palette_word_i == '0);
    for (int k = 0; k < 3; k++) begin
      cap_d.ent_ok[k] = (32'(ent[k]) < 32'(CT_ENTRIES));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
    end else if (accept) begin
      cap_valid_q <= is_draw;
    end else if (row_load) begin
      cap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_draw) begin
      cap_q <= cap_d;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_table
    ptr_color_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (load_we),
      .waddr_i (CT_AW'(entry_index_i)),
      .wdata_i (entry_rgb_i),
      .re_i    (accept && is_draw),
      .raddr_i (CT_AW'(ent[k])),
      .rdata_o (rgb[k])
    );
  end

  ptr_row_decode u_decode (
    .cap_i (cap_q),
    .rgb_i (rgb),
    .row_o (row)
  );

  ptr_pixel_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cap_valid_i     (cap_valid_q),
    .row_i           (row),
    .row_load_o      (row_load),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

`default_nettype wire
